// ----- rtl/core/pcba_pkg.sv -----
`default_nettype none
package pcba_pkg;
  localparam logic [63:0] GOLDEN_K = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SEED_K   = 64'hA5A5A5A5A5A5A5A5;

  typedef enum logic [1:0] {
    ACT_BEGIN   = 2'd0,
    ACT_TOKEN   = 2'd1,
    ACT_ALLOC   = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOBLOCK = 2'd1,
    ST_BADREL  = 2'd2
  } status_t;

  localparam logic REG_SPAN_SIZE = 1'b0;
  localparam logic REG_ENABLE    = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/core/prefix_cache_block_allocator.sv -----
`default_nettype none
// Channel  Direction  Payload
// s_axis   in         tdata {token[42:11], has_parent[10], block_id[9:2], action[1:0]}
// m_axis   out        tdata {miss_total[74:43], hit_total[42:11], was_hit[10],
//                            status[9:8], result_block[7:0]}
// cfg      in         cfg_index, cfg_data
// Begin, token and release requests pass through the read, execute and output states.
// A keyed allocate sweeps the hash memory one block per cycle and, on a hit, walks
// the idle list one entry per cycle.
// After reset a fill pass writes the free stack and clears the hash and count
// memories while s_axis_tready stays low.
// A result waits in its output register while the next request runs; the last step of
// a request stalls only while that register is still full.
module prefix_cache_block_allocator #(
  parameter int BLOCK_COUNT = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // action, block_id, has_parent, token
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [79:0] m_axis_tdata,   // result_block, status, was_hit, hit_total, miss_total
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import pcba_pkg::*;

  localparam int AW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int DW = AW + 1;
  localparam logic [DW-1:0] NB = DW'(BLOCK_COUNT);

  typedef enum logic [10:0] {
    S_FILL  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_EXEC  = 11'b00000001000,
    S_SRCH  = 11'b00000010000,
    S_HIT   = 11'b00000100000,
    S_IFIND = 11'b00001000000,
    S_ISHF  = 11'b00010000000,
    S_FRESH = 11'b00100000000,
    S_FWR   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  logic [63:0] hash_mem [BLOCK_COUNT];
  logic [15:0] cnt_mem  [BLOCK_COUNT];
  logic [AW-1:0] free_mem [BLOCK_COUNT];
  logic [AW-1:0] idle_mem [BLOCK_COUNT];

  logic [8:0]  span_size;
  logic        cache_en;
  logic [63:0] running_hash;
  logic [8:0]  span_tokens;
  logic [31:0] hit_counter, miss_counter;
  logic [DW-1:0] free_depth, idle_depth;

  logic [1:0]  act;
  logic [7:0]  bid;
  logic        has_parent;
  logic [31:0] token;
  logic [63:0] key;
  logic        keyed;
  logic [DW-1:0] idx;
  logic [DW-1:0] shf_idx;
  logic [AW-1:0] blk;
  logic [63:0] hash_rd;
  logic [15:0] cnt_rd;
  logic [AW-1:0] free_rd, idle_rd, idle_top_rd;
  logic [7:0]  result_block;
  logic [1:0]  status;
  logic        was_hit;
  logic        bid_ok;
  logic        out_go;
  logic [74:0] out_data;

  assign bid_ok = {24'd0, bid} < BLOCK_COUNT;
  assign out_go = !m_axis_tvalid || m_axis_tready;
  assign shf_idx = idx - DW'(2);
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {5'd0, out_data};

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == {7'd0, REG_SPAN_SIZE}) begin
        span_size <= cfg_data[8:0];
      end else if (cfg_index == {7'd0, REG_ENABLE}) begin
        cache_en <= cfg_data[0];
      end
    end
    if (rst) begin
      span_size <= 9'd16;
      cache_en  <= 1'b1;
    end
  end

  // Memory ports: registered reads, at most two read addresses per memory each cycle.
  always_ff @(posedge clk) begin
    hash_rd <= hash_mem[blk];
    cnt_rd  <= cnt_mem[blk];
    free_rd <= free_mem[free_depth[AW-1:0] - AW'(1)];
    idle_rd <= idle_mem[idx[AW-1:0]];
    idle_top_rd <= idle_mem[idle_depth[AW-1:0] - AW'(1)];
  end

  always_ff @(posedge clk) begin
    if (state == S_FILL) begin
      hash_mem[idx[AW-1:0]] <= '0;
      cnt_mem[idx[AW-1:0]]  <= '0;
      free_mem[idx[AW-1:0]] <= AW'(BLOCK_COUNT - 1) - idx[AW-1:0];
    end else if (state == S_OUT && was_hit && out_go) begin
      if (cnt_rd != 16'hFFFF) cnt_mem[blk] <= cnt_rd + 16'd1;
    end else if (state == S_ISHF && idx <= idle_depth) begin
      idle_mem[shf_idx[AW-1:0]] <= idle_rd;
    end else if (state == S_FWR) begin
      cnt_mem[blk]  <= 16'd1;
      hash_mem[blk] <= keyed ? key : 64'd0;
    end else if (state == S_EXEC && act == ACT_RELEASE && bid_ok && cnt_rd != 16'd0) begin
      cnt_mem[blk] <= cnt_rd - 16'd1;
      if (cnt_rd == 16'd1) begin
        if (hash_rd != 64'd0) begin
          if (idle_depth < NB) idle_mem[idle_depth[AW-1:0]] <= blk;
        end else if (free_depth < NB) begin
          free_mem[free_depth[AW-1:0]] <= blk;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      idx <= '0;
      blk <= '0;
      free_depth <= NB;
      idle_depth <= '0;
      running_hash <= '0;
      span_tokens <= '0;
      hit_counter <= '0;
      miss_counter <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_go) begin
        m_axis_tvalid <= 1'b1;
        out_data <= {miss_counter, hit_counter, was_hit, status, result_block};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          idx <= idx + DW'(1);
          if (idx == NB - DW'(1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            act <= s_axis_tdata[1:0];
            bid <= s_axis_tdata[9:2];
            has_parent <= s_axis_tdata[10];
            token <= s_axis_tdata[42:11];
            blk <= (s_axis_tdata[1:0] == ACT_ALLOC) ? '0 : AW'(s_axis_tdata[9:2]);
            result_block <= '0;
            status <= ST_OK;
            was_hit <= 1'b0;
            keyed <= (span_tokens == span_size) && cache_en;
            key <= (running_hash == 64'd0) ? 64'd1 : running_hash;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (act == ACT_ALLOC) begin
            blk <= AW'(1);
            idx <= '0;
            state <= keyed ? S_SRCH : S_FRESH;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          case (act)
            ACT_BEGIN: begin
              running_hash <= ((has_parent && bid_ok) ? hash_rd : 64'd0) ^ SEED_K;
              span_tokens <= '0;
            end
            ACT_TOKEN: begin
              running_hash <= running_hash ^ ({32'd0, token} + GOLDEN_K +
                              (running_hash << 6) + (running_hash >> 2));
              if (span_tokens != 9'd511) span_tokens <= span_tokens + 9'd1;
            end
            ACT_RELEASE: begin
              if (!bid_ok || cnt_rd == 16'd0) begin
                status <= ST_BADREL;
              end else if (cnt_rd == 16'd1) begin
                if (hash_rd != 64'd0) begin
                  if (idle_depth < NB) idle_depth <= idle_depth + DW'(1);
                end else if (free_depth < NB) begin
                  free_depth <= free_depth + DW'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_SRCH: begin
          // hash_rd holds the stored hash of block idx.
          if (hash_rd == key) begin
            blk <= idx[AW-1:0];
            idx <= '0;
            state <= S_HIT;
          end else if (idx == NB - DW'(1)) begin
            state <= S_FRESH;
          end else begin
            idx <= idx + DW'(1);
            blk <= blk + AW'(1);
          end
        end
        S_HIT: begin
          result_block <= 8'(blk);
          was_hit <= 1'b1;
          if (hit_counter != 32'hFFFFFFFF) hit_counter <= hit_counter + 32'd1;
          idx <= DW'(1);
          state <= S_IFIND;
        end
        S_IFIND: begin
          if (idx > idle_depth) begin
            state <= S_OUT;
          end else if (idle_rd == blk) begin
            idx <= idx + DW'(1);
            state <= S_ISHF;
          end else begin
            idx <= idx + DW'(1);
          end
        end
        S_ISHF: begin
          if (idx > idle_depth) begin
            idle_depth <= idle_depth - DW'(1);
            state <= S_OUT;
          end else begin
            idx <= idx + DW'(1);
          end
        end
        S_FRESH: begin
          if (free_depth != '0) begin
            free_depth <= free_depth - DW'(1);
            blk <= free_rd;
            state <= S_FWR;
          end else if (idle_depth != '0) begin
            idle_depth <= idle_depth - DW'(1);
            blk <= idle_top_rd;
            state <= S_FWR;
          end else begin
            status <= ST_NOBLOCK;
            state <= S_OUT;
          end
        end
        S_FWR: begin
          result_block <= 8'(blk);
          if (keyed && miss_counter != 32'hFFFFFFFF) miss_counter <= miss_counter + 32'd1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_go) state <= S_IDLE;
        end
        default: state <= S_FILL;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_axis_tready) else $error("ready while busy");
  a_depth_free: assert property (@(posedge clk) disable iff (rst)
    free_depth <= NB) else $error("free depth overflow");
  a_depth_idle: assert property (@(posedge clk) disable iff (rst)
    idle_depth <= NB) else $error("idle depth overflow");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> m_axis_tvalid) else $error("result lost");
endmodule
`default_nettype wire

// ----- dv/tb_prefix_cache_block_allocator.sv -----
`timescale 1ns / 100ps
module tb_prefix_cache_block_allocator;
  import pcba_pkg::*;

  localparam int NB = 256;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [31:0] token;
    logic        has_parent;
    logic [7:0]  block_id;
    action_t     action;
  } request_t;

  typedef struct packed {
    logic [31:0] miss_total;
    logic [31:0] hit_total;
    logic        was_hit;
    status_t     status;
    logic [7:0]  result_block;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  prefix_cache_block_allocator #(.BLOCK_COUNT(NB)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Allocator shadow state.
  logic [8:0]  span_len;
  logic        cache_on;
  logic [15:0] refs [NB];
  logic [63:0] hashes [NB];
  logic [7:0]  free_q [$];
  logic [7:0]  idle_q [$];
  logic [63:0] chain;
  logic [8:0]  mixed;
  logic [31:0] hits, misses;

  request_t pending_q [$];
  grant_t   grant_q [$];
  int errors = 0;
  int accepted = 0;
  int granted = 0;
  int hit_seen = 0;
  int send_idle = 0;
  int recv_stall = 0;
  longint cycles = 0;

  function automatic grant_t predict_grant(request_t r);
    grant_t g;
    logic [63:0] key;
    int found;
    bit keyed;
    g = '0;
    g.status = ST_OK;
    case (r.action)
      ACT_BEGIN: begin
        chain = (r.has_parent ? hashes[r.block_id] : 64'd0) ^ SEED_K;
        mixed = '0;
      end
      ACT_TOKEN: begin
        chain = chain ^ ({32'd0, r.token} + GOLDEN_K + (chain << 6) + (chain >> 2));
        if (mixed != 9'd511) mixed = mixed + 9'd1;
      end
      ACT_ALLOC: begin
        keyed = (mixed == span_len) && cache_on;
        key = (chain == 64'd0) ? 64'd1 : chain;
        found = -1;
        if (keyed)
          for (int i = 0; i < NB; i++)
            if (found < 0 && hashes[i] == key) found = i;
        if (found >= 0) begin
          for (int i = 0; i < idle_q.size(); i++)
            if (idle_q[i] == found[7:0]) begin
              idle_q.delete(i);
              break;
            end
          if (refs[found] != 16'hFFFF) refs[found]++;
          if (hits != 32'hFFFFFFFF) hits++;
          g.result_block = found[7:0];
          g.was_hit = 1'b1;
        end else if (free_q.size() == 0 && idle_q.size() == 0) begin
          g.status = ST_NOBLOCK;
        end else begin
          if (free_q.size() > 0) begin
            g.result_block = free_q[$];
            free_q.delete(free_q.size() - 1);
          end else begin
            g.result_block = idle_q[$];
            idle_q.delete(idle_q.size() - 1);
          end
          refs[g.result_block] = 16'd1;
          hashes[g.result_block] = keyed ? key : 64'd0;
          if (keyed && misses != 32'hFFFFFFFF) misses++;
        end
      end
      default: begin
        if (refs[r.block_id] == 16'd0) begin
          g.status = ST_BADREL;
        end else begin
          refs[r.block_id]--;
          if (refs[r.block_id] == 16'd0) begin
            if (hashes[r.block_id] != 64'd0) idle_q = {idle_q, r.block_id};
            else free_q = {free_q, r.block_id};
          end
        end
      end
    endcase
    g.hit_total = hits;
    g.miss_total = misses;
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        grant_q = {grant_q, predict_grant(request_t'(s_axis_tdata[42:0]))};
        accepted++;
      end
      if (pending_q.size() > 0 && (!s_axis_tvalid || s_axis_tready)
          && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= 48'(pending_q.pop_front());
      end else if (s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    grant_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = grant_t'(m_axis_tdata[74:0]);
        granted++;
        if (got.was_hit) hit_seen++;
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (got.result_block != want.result_block || got.status != want.status
              || got.was_hit != want.was_hit || got.hit_total != want.hit_total
              || got.miss_total != want.miss_total) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || grant_q.size() > 0) @(posedge clk);
    repeat (2 * NB + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == 8'(REG_SPAN_SIZE)) span_len = val[8:0];
    else if (idx == 8'(REG_ENABLE)) cache_on = val[0];
  endtask

  task automatic add(action_t a, logic [7:0] b, logic p, logic [31:0] t);
    request_t r;
    r.action = a;
    r.block_id = b;
    r.has_parent = p;
    r.token = t;
    pending_q = {pending_q, r};
  endtask

  // A span of n tokens with random content, optionally chained to a parent block.
  task automatic add_span(int n, logic [7:0] parent, logic chained, int vocab);
    add(ACT_BEGIN, parent, chained, $urandom);
    for (int i = 0; i < n; i++)
      add(ACT_TOKEN, 8'($urandom), 1'($urandom), $urandom_range(vocab));
    add(ACT_ALLOC, 8'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic random_phase(int count, int len);
    logic [7:0] last;
    int k;
    last = '0;
    k = 0;
    while (k < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          add_span(len, last, 1'($urandom_range(1)), 3);
          k += len + 2;
        end
        4, 5: begin
          add(ACT_RELEASE, (free_q.size() < 8) ? 8'($urandom_range(NB - 1))
                                               : 8'($urandom_range(40)), 1'b0, $urandom);
          k++;
        end
        6: begin
          add(ACT_ALLOC, 8'($urandom), 1'($urandom), $urandom);
          k++;
        end
        7: begin
          add(ACT_TOKEN, 8'($urandom), 1'($urandom), $urandom);
          k++;
        end
        8: begin
          add(ACT_BEGIN, 8'($urandom), 1'($urandom), $urandom);
          k++;
        end
        default: begin
          for (int i = 0; i < 4; i++) add(ACT_RELEASE, 8'($urandom_range(40)), 1'b0, 32'd0);
          k += 4;
        end
      endcase
      last = 8'($urandom_range(40));
    end
  endtask

  initial begin
    span_len = 9'd16;
    cache_on = 1'b1;
    chain = '0;
    mixed = '0;
    hits = '0;
    misses = '0;
    for (int i = 0; i < NB; i++) begin
      refs[i] = '0;
      hashes[i] = '0;
      free_q = {free_q, 8'(NB - 1 - i)};
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_reg(8'(REG_SPAN_SIZE), 2);
    add_span(2, 8'd0, 1'b0, 0);
    add_span(2, 8'd0, 1'b0, 0);
    add(ACT_TOKEN, 8'hFF, 1'b1, 32'hFFFFFFFF);
    add(ACT_ALLOC, 8'hFF, 1'b1, 32'hFFFFFFFF);
    add(ACT_RELEASE, 8'd0, 1'b0, 32'd0);
    add(ACT_RELEASE, 8'd0, 1'b0, 32'd0);
    add(ACT_RELEASE, 8'd0, 1'b0, 32'd0);
    add(ACT_RELEASE, 8'hFF, 1'b1, 32'hFFFFFFFF);
    add(ACT_BEGIN, 8'd0, 1'b1, 32'd0);
    add(ACT_TOKEN, 8'd0, 1'b0, 32'd0);
    add(ACT_TOKEN, 8'd0, 1'b0, 32'd0);
    add(ACT_ALLOC, 8'd0, 1'b0, 32'd0);
    add(ACT_BEGIN, 8'hFF, 1'b1, 32'd0);
    drain();

    write_reg(8'(REG_SPAN_SIZE), 0);
    write_reg(8'(REG_ENABLE), 0);
    write_reg(8'd7, 32'hFFFFFFFF);
    add(ACT_BEGIN, 8'd3, 1'b0, 32'd0);
    add(ACT_ALLOC, 8'd0, 1'b0, 32'd0);
    drain();
    write_reg(8'(REG_ENABLE), 1);
    add(ACT_BEGIN, 8'd3, 1'b0, 32'd0);
    add(ACT_ALLOC, 8'd0, 1'b0, 32'd0);
    add(ACT_ALLOC, 8'd0, 1'b0, 32'd0);
    drain();

    // Exhaust every block so no-block status is reached. The token keeps these
    // allocates unkeyed, so none of them can reuse a cached block.
    add(ACT_TOKEN, 8'd0, 1'b0, 32'd1);
    for (int i = 0; i < 258; i++) add(ACT_ALLOC, 8'd0, 1'b0, 32'd0);
    drain();

    write_reg(8'(REG_SPAN_SIZE), 1);
    send_idle = 0; recv_stall = 0;
    random_phase(200, 1);
    drain();
    write_reg(8'(REG_SPAN_SIZE), 3);
    send_idle = 48; recv_stall = 0;
    random_phase(200, 3);
    drain();
    write_reg(8'(REG_ENABLE), 0);
    send_idle = 0; recv_stall = 48;
    random_phase(150, 2);
    drain();
    write_reg(8'(REG_ENABLE), 1);
    write_reg(8'(REG_SPAN_SIZE), 2);
    send_idle = 13; recv_stall = 13;
    random_phase(200, 2);
    drain();
    write_reg(8'(REG_SPAN_SIZE), 256);
    send_idle = 0; recv_stall = 0;
    add_span(256, 8'd0, 1'b0, 0);
    add_span(256, 8'd0, 1'b0, 0);
    drain();
    write_reg(8'(REG_SPAN_SIZE), 511);
    add_span(3, 8'd0, 1'b0, 5);
    drain();

    $display("Checked %0d requests and %0d results, %0d of them prefix hits,", accepted,
             granted, hit_seen);
    $display("over span lengths 0 to 256, caching on and off, and varied back-pressure.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
